// ----- rtl/core/sbme_pkg.sv -----
// Shared types and constants for the SMBus master bit engine.
package sbme_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT        = 2'd1;

  localparam logic [7:0] START_STOP_RST = 8'd5;
  localparam logic [7:0] BIT_RST        = 8'd6;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_MACK  = 3'd5;
  localparam logic [2:0] OP_STOP  = 3'd6;

  localparam logic [1:0] ACK_OK    = 2'd0;
  localparam logic [1:0] ACK_HELD  = 2'd1;
  localparam logic [1:0] ACK_ROSE  = 2'd2;
  localparam logic [1:0] ACK_NONE  = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [6:0] {
    CMD_IDLE  = 7'b0000001,
    CMD_START = 7'b0000010,
    CMD_WRITE = 7'b0000100,
    CMD_ACK   = 7'b0001000,
    CMD_READ  = 7'b0010000,
    CMD_MACK  = 7'b0100000,
    CMD_STOP  = 7'b1000000
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] phase;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic       scl;
    logic       sda;
    logic [1:0] ack;
    logic [7:0] read_byte;
  } eng_state_t;

  typedef struct packed {
    logic [7:0] start_stop_ticks;
    logic [7:0] bit_ticks;
  } cfg_regs_t;

endpackage

// ----- rtl/core/sbme_cfg.sv -----
// Configuration register file for the delay step lengths.
module sbme_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output sbme_pkg::cfg_regs_t             regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_stop_ticks <= sbme_pkg::START_STOP_RST;
      regs.bit_ticks        <= sbme_pkg::BIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == sbme_pkg::CFG_START_STOP) begin
        regs.start_stop_ticks <= cfg_data;
      end else if (cfg_index == sbme_pkg::CFG_BIT) begin
        regs.bit_ticks <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/core/sbme_seq.sv -----
// Next-state logic of the bit sequencer for one tick.
module sbme_seq #(
  parameter int unsigned DELAY_BITS = 8
) (
  input  sbme_pkg::eng_state_t    st,
  input  logic [DELAY_BITS-1:0]   delay,
  input  sbme_pkg::cfg_regs_t     regs,
  input  logic [2:0]              operation,
  input  logic [7:0]              byte_out,
  input  logic                    sda_in,
  output sbme_pkg::eng_state_t    st_next,
  output logic [DELAY_BITS-1:0]   delay_next,
  output logic                    done
);

  localparam int unsigned CW    = (DELAY_BITS > 8) ? DELAY_BITS : 8;
  localparam int unsigned LIMIT = (1 << DELAY_BITS) - 1;

  logic [CW-1:0]         raw;
  logic [CW-1:0]         len_w;
  logic [DELAY_BITS-1:0] step_len;
  logic                  load;
  logic                  fin;
  logic [2:0]            bit_sel;

  assign bit_sel = 3'd7 - st.bit_index[2:0];

  // Step length follows the command that the step belongs to.
  always_comb begin
    if (st_next.cmd == sbme_pkg::CMD_START || st_next.cmd == sbme_pkg::CMD_STOP) begin
      raw = CW'(regs.start_stop_ticks);
    end else begin
      raw = CW'(regs.bit_ticks);
    end
    len_w = raw;
    if (raw == '0) begin
      len_w = CW'(1);
    end else if (raw > CW'(LIMIT)) begin
      len_w = CW'(LIMIT);
    end
    step_len = len_w[DELAY_BITS-1:0];
  end

  always_comb begin
    st_next = st;
    load    = 1'b0;
    fin     = 1'b0;
    if (st.cmd == sbme_pkg::CMD_IDLE) begin
      st_next.bit_index = st.bit_index;
      st_next.phase     = st.phase;
      unique case (operation)
        sbme_pkg::OP_START: begin
          st_next.cmd = sbme_pkg::CMD_START;
          st_next.sda = 1'b1;
          st_next.scl = 1'b1;
          load = 1'b1;
        end
        sbme_pkg::OP_WRITE: begin
          st_next.cmd        = sbme_pkg::CMD_WRITE;
          st_next.shift_byte = byte_out;
          st_next.scl        = 1'b0;
          load = 1'b1;
        end
        sbme_pkg::OP_ACK: begin
          st_next.cmd = sbme_pkg::CMD_ACK;
          st_next.scl = 1'b0;
          load = 1'b1;
        end
        sbme_pkg::OP_READ: begin
          st_next.cmd        = sbme_pkg::CMD_READ;
          st_next.shift_byte = '0;
          load = 1'b1;
        end
        sbme_pkg::OP_MACK: begin
          st_next.cmd = sbme_pkg::CMD_MACK;
          st_next.scl = 1'b0;
          st_next.sda = 1'b0;
          load = 1'b1;
        end
        sbme_pkg::OP_STOP: begin
          st_next.cmd = sbme_pkg::CMD_STOP;
          load = 1'b1;
        end
        default: begin
        end
      endcase
      if (load) begin
        st_next.bit_index = '0;
        st_next.phase     = '0;
      end
    end else if (delay > DELAY_BITS'(1)) begin
      st_next = st;
    end else begin
      unique case (st.cmd)
        sbme_pkg::CMD_START: begin
          if (st.phase == 2'd0) begin
            st_next.sda = 1'b0; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            st_next.scl = 1'b0; st_next.phase = 2'd2; load = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        sbme_pkg::CMD_WRITE: begin
          if (st.phase == 2'd0) begin
            st_next.sda = st.shift_byte[bit_sel]; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            st_next.scl = 1'b1; st_next.phase = 2'd2; load = 1'b1;
          end else begin
            st_next.bit_index = st.bit_index + 4'd1;
            if (st_next.bit_index >= sbme_pkg::BITS_PER_BYTE) begin
              fin = 1'b1;
            end else begin
              st_next.scl = 1'b0; st_next.phase = 2'd0; load = 1'b1;
            end
          end
        end
        sbme_pkg::CMD_ACK: begin
          if (st.phase == 2'd0) begin
            st_next.sda = 1'b1; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            if (sda_in) begin
              st_next.ack = sbme_pkg::ACK_NONE; fin = 1'b1;
            end else begin
              st_next.scl = 1'b1; st_next.phase = 2'd2; load = 1'b1;
            end
          end else if (st.phase == 2'd2) begin
            if (sda_in) begin
              st_next.ack = sbme_pkg::ACK_ROSE; fin = 1'b1;
            end else begin
              st_next.scl = 1'b0; st_next.phase = 2'd3; load = 1'b1;
            end
          end else begin
            st_next.ack = sda_in ? sbme_pkg::ACK_OK : sbme_pkg::ACK_HELD;
            fin = 1'b1;
          end
        end
        sbme_pkg::CMD_READ: begin
          if (st.phase == 2'd0) begin
            st_next.scl = 1'b0; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            st_next.shift_byte[bit_sel] = sda_in;
            st_next.scl = 1'b1; st_next.phase = 2'd2; load = 1'b1;
          end else begin
            st_next.bit_index = st.bit_index + 4'd1;
            if (st_next.bit_index >= sbme_pkg::BITS_PER_BYTE) begin
              st_next.read_byte = st.shift_byte;
              fin = 1'b1;
            end else begin
              st_next.scl = 1'b0; st_next.phase = 2'd1; load = 1'b1;
            end
          end
        end
        sbme_pkg::CMD_MACK: begin
          if (st.phase == 2'd0) begin
            st_next.scl = 1'b1; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            st_next.scl = 1'b0; st_next.phase = 2'd2; load = 1'b1;
          end else if (st.phase == 2'd2) begin
            st_next.sda = 1'b1; st_next.phase = 2'd3; load = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        sbme_pkg::CMD_STOP: begin
          if (st.phase == 2'd0) begin
            st_next.sda = 1'b0; st_next.phase = 2'd1; load = 1'b1;
          end else if (st.phase == 2'd1) begin
            st_next.scl = 1'b1; st_next.phase = 2'd2; load = 1'b1;
          end else if (st.phase == 2'd2) begin
            st_next.sda = 1'b1; st_next.phase = 2'd3; load = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
      if (fin) begin
        st_next.cmd   = sbme_pkg::CMD_IDLE;
        st_next.phase = '0;
      end
    end
  end

  always_comb begin
    if (load) begin
      delay_next = step_len;
    end else if (fin) begin
      delay_next = '0;
    end else if (st.cmd != sbme_pkg::CMD_IDLE) begin
      delay_next = delay - DELAY_BITS'(1);
    end else begin
      delay_next = delay;
    end
  end

  assign done = fin;

endmodule

// ----- rtl/core/smbus_master_bit_engine.sv -----
// Top level of the SMBus master bit engine: state, result register and handshakes.
// Each input word is one timing tick and yields exactly one result word. The
// engine takes one tick word per clock cycle; the sequencer's next state is
// combinational and the result register sits between it and the output, so a new
// tick is taken whenever the result register is empty or its word is taken in the
// same cycle. A command runs for the delay steps of its sequence; the ack check can
// end after its second or third step when the sampled SDA level is high. Each step
// lasts the configured tick count (clamped to 1 .. 2^DELAY_BITS-1).
module smbus_master_bit_engine #(
  parameter int unsigned DELAY_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     operation,
  input  logic [7:0]                     byte_out,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           scl_level,
  output logic                           sda_level,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [7:0]                     read_data,
  output logic [1:0]                     ack_code
);

  sbme_pkg::cfg_regs_t   regs;
  sbme_pkg::eng_state_t  st;
  sbme_pkg::eng_state_t  st_next;
  logic [DELAY_BITS-1:0] delay;
  logic [DELAY_BITS-1:0] delay_next;
  logic                  done;
  logic                  take;

  sbme_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  sbme_seq #(
    .DELAY_BITS (DELAY_BITS)
  ) u_seq (
    .st         (st),
    .delay      (delay),
    .regs       (regs),
    .operation  (operation),
    .byte_out   (byte_out),
    .sda_in     (sda_in),
    .st_next    (st_next),
    .delay_next (delay_next),
    .done       (done)
  );

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd        <= sbme_pkg::CMD_IDLE;
      st.phase      <= '0;
      st.bit_index  <= '0;
      st.shift_byte <= '0;
      st.scl        <= 1'b1;
      st.sda        <= 1'b1;
      st.ack        <= sbme_pkg::ACK_OK;
      st.read_byte  <= '0;
      delay         <= '0;
    end else if (take) begin
      st    <= st_next;
      delay <= delay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scl_level <= st_next.scl;
      sda_level <= st_next.sda;
      busy_res  <= (st_next.cmd != sbme_pkg::CMD_IDLE);
      done_res  <= done;
      read_data <= st_next.read_byte;
      ack_code  <= st_next.ack;
    end
  end

endmodule

// ----- tb/smbus_master_bit_engine_tb.sv -----
// Testbench for the SMBus master bit engine: randomized tick stream against a built-in predictor.
module smbus_master_bit_engine_tb;
  import sbme_pkg::*;

  localparam logic [2:0] CMD_NONE = OP_TICK;
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int CYCLE_LIMIT = 150000;

  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
    logic       sda;
  } tick_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic [1:0] ack;
  } lines_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = OP_TICK;
  logic [7:0] byte_out = '0;
  logic sda_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic done_res;
  logic [7:0] read_data;
  logic [1:0] ack_code;

  smbus_master_bit_engine dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .byte_out(byte_out), .sda_in(sda_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_level(sda_level), .busy_res(busy_res),
    .done_res(done_res), .read_data(read_data), .ack_code(ack_code)
  );

  tick_word_t tick_q[$];
  lines_t     line_q[$];
  lines_t     want;

  logic       steady = 1'b0;
  int         err_count = 0;
  int         words_in = 0;
  int         results_seen = 0;
  int         cmds_done = 0;
  int         settings_run = 0;
  int         cycles = 0;

  logic [7:0] ss_ticks = START_STOP_RST;
  logic [7:0] bit_ticks = BIT_RST;

  logic [2:0] eng_cmd = CMD_NONE;
  logic [2:0] eng_phase = '0;
  logic [7:0] eng_wait = '0;
  logic [3:0] eng_bit = '0;
  logic [7:0] eng_shift = '0;
  logic       eng_scl = 1'b1;
  logic       eng_sda = 1'b1;
  logic [1:0] eng_ack = ACK_OK;
  logic [7:0] eng_rd = '0;

  function automatic logic [7:0] step_ticks(input logic [2:0] cmd);
    logic [7:0] d;
    d = (cmd == OP_START || cmd == OP_STOP) ? ss_ticks : bit_ticks;
    if (d == 8'd0) d = 8'd1;
    return d;
  endfunction

  function automatic void load_phase(input logic [2:0] p);
    eng_phase = p;
    eng_wait = step_ticks(eng_cmd);
  endfunction

  function automatic logic expire_step(input logic sda);
    logic fin;
    fin = 1'b0;
    case (eng_cmd)
      OP_START: begin
        if (eng_phase == 0) begin eng_sda = 1'b0; load_phase(1); end
        else if (eng_phase == 1) begin eng_scl = 1'b0; load_phase(2); end
        else fin = 1'b1;
      end
      OP_WRITE: begin
        if (eng_phase == 0) begin
          eng_sda = eng_shift[7 - eng_bit[2:0]];
          load_phase(1);
        end else if (eng_phase == 1) begin
          eng_scl = 1'b1;
          load_phase(2);
        end else begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit >= BITS_PER_BYTE) fin = 1'b1;
          else begin eng_scl = 1'b0; load_phase(0); end
        end
      end
      OP_ACK: begin
        if (eng_phase == 0) begin
          eng_sda = 1'b1;
          load_phase(1);
        end else if (eng_phase == 1) begin
          if (sda) begin eng_ack = ACK_NONE; fin = 1'b1; end
          else begin eng_scl = 1'b1; load_phase(2); end
        end else if (eng_phase == 2) begin
          if (sda) begin eng_ack = ACK_ROSE; fin = 1'b1; end
          else begin eng_scl = 1'b0; load_phase(3); end
        end else begin
          eng_ack = sda ? ACK_OK : ACK_HELD;
          fin = 1'b1;
        end
      end
      OP_READ: begin
        if (eng_phase == 0) begin
          eng_scl = 1'b0;
          load_phase(1);
        end else if (eng_phase == 1) begin
          eng_shift[7 - eng_bit[2:0]] = sda;
          eng_scl = 1'b1;
          load_phase(2);
        end else begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit >= BITS_PER_BYTE) begin eng_rd = eng_shift; fin = 1'b1; end
          else begin eng_scl = 1'b0; load_phase(1); end
        end
      end
      OP_MACK: begin
        if (eng_phase == 0) begin eng_scl = 1'b1; load_phase(1); end
        else if (eng_phase == 1) begin eng_scl = 1'b0; load_phase(2); end
        else if (eng_phase == 2) begin eng_sda = 1'b1; load_phase(3); end
        else fin = 1'b1;
      end
      OP_STOP: begin
        if (eng_phase == 0) begin eng_sda = 1'b0; load_phase(1); end
        else if (eng_phase == 1) begin eng_scl = 1'b1; load_phase(2); end
        else if (eng_phase == 2) begin eng_sda = 1'b1; load_phase(3); end
        else fin = 1'b1;
      end
      default: fin = 1'b1;
    endcase
    if (fin) begin
      eng_cmd = CMD_NONE;
      eng_phase = '0;
      eng_wait = '0;
    end
    return fin;
  endfunction

  function automatic void advance_engine(input logic [2:0] op, input logic [7:0] data,
                                         input logic sda);
    lines_t r;
    logic fin;
    fin = 1'b0;
    if (eng_cmd == CMD_NONE) begin
      if (op >= OP_START && op <= OP_STOP) begin
        eng_cmd = op;
        eng_bit = '0;
        case (op)
          OP_START: begin eng_sda = 1'b1; eng_scl = 1'b1; end
          OP_WRITE: begin eng_shift = data; eng_scl = 1'b0; end
          OP_ACK:   eng_scl = 1'b0;
          OP_READ:  eng_shift = '0;
          OP_MACK:  begin eng_scl = 1'b0; eng_sda = 1'b0; end
          default: ;
        endcase
        load_phase(0);
      end
    end else if (eng_wait > 8'd1) begin
      eng_wait = eng_wait - 8'd1;
    end else begin
      fin = expire_step(sda);
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_cmd != CMD_NONE);
    r.done = fin;
    r.rd = eng_rd;
    r.ack = eng_ack;
    line_q.push_back(r);
  endfunction

  function automatic int cmd_steps(input logic [2:0] op);
    case (op)
      OP_START: return 3;
      OP_WRITE: return 24;
      OP_ACK:   return 4;
      OP_READ:  return 17;
      OP_MACK:  return 4;
      OP_STOP:  return 4;
      default:  return 0;
    endcase
  endfunction

  task automatic queue_word(input logic [2:0] op, input logic [7:0] data, input logic sda);
    tick_word_t w;
    w.op = op;
    w.data = data;
    w.sda = sda;
    tick_q.push_back(w);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Frames of start, address write, ack, data writes or reads, stop; some commands garbled.
  task automatic gen_frames(input int n);
    logic [2:0] frame[$];
    logic [2:0] op;
    logic [7:0] data;
    int made;
    int ticks;
    made = 0;
    while (made < n) begin
      frame.delete();
      frame.push_back(OP_START);
      frame.push_back(OP_WRITE);
      frame.push_back(OP_ACK);
      repeat ($urandom_range(3)) begin
        if ($urandom_range(1) == 0) begin
          frame.push_back(OP_WRITE);
          frame.push_back(OP_ACK);
        end else begin
          frame.push_back(OP_READ);
          frame.push_back(OP_MACK);
        end
      end
      frame.push_back(OP_STOP);
      foreach (frame[i]) begin
        if (made >= n) break;
        op = ($urandom_range(9) < 2) ? 3'($urandom_range(7)) : frame[i];
        data = 8'($urandom);
        if ($urandom_range(9) == 0) data = $urandom_range(1) ? 8'hFF : 8'h00;
        queue_word(op, data, 1'($urandom));
        ticks = cmd_steps(op) * step_ticks(op) + $urandom_range(2);
        if ($urandom_range(7) == 0) ticks = (ticks > 3) ? ticks - $urandom_range(1, 3) : 0;
        repeat (ticks) begin
          op = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : OP_TICK;
          queue_word(op, 8'($urandom), 1'($urandom));
        end
        made += ticks + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_START_STOP) ss_ticks = val;
    else if (idx == CFG_BIT) bit_ticks = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_delays(input logic [7:0] ss, input logic [7:0] bt);
    write_reg(CFG_START_STOP, ss);
    write_reg(CFG_BIT, bt);
    settings_run++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (tick_q.size() != 0 || line_q.size() != 0 || in_valid);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, line_q.size());
      $display("smbus_master_bit_engine_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        void'(tick_q.pop_front());
        advance_engine(operation, byte_out, sda_in);
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          operation <= tick_q[0].op;
          byte_out <= tick_q[0].data;
          sda_in <= tick_q[0].sda;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (line_q.size() == 0) begin
          err_count++;
          $display("%0t: result word with none expected, actual scl %b sda %b", $time,
                   scl_level, sda_level);
        end else begin
          want = line_q.pop_front();
          check_field("scl_level", 8'(want.scl), 8'(scl_level));
          check_field("sda_level", 8'(want.sda), 8'(sda_level));
          check_field("busy_res", 8'(want.busy), 8'(busy_res));
          check_field("done_res", 8'(want.done), 8'(done_res));
          check_field("read_data", want.rd, read_data);
          check_field("ack_code", 8'(want.ack), 8'(ack_code));
          results_seen++;
          if (want.done) cmds_done++;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset delays
    @(negedge clk);
    gen_frames(120);
    wait_quiet();

    // one-tick steps from a zero register; spare indexes must be ignored
    set_delays(8'd0, 8'd0);
    write_reg(CFG_UNUSED_LO, 8'hAA);
    write_reg(CFG_UNUSED_HI, 8'h55);
    @(negedge clk);
    queue_word(OP_SPARE, 8'h3C, 1'b1);
    queue_word(OP_START, 8'h00, 1'b0);
    queue_word(OP_STOP, 8'hFF, 1'b1);
    queue_ticks(2);
    queue_word(OP_ACK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_ACK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_ACK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_ACK, 8'h00, 1'b1);
    queue_word(OP_TICK, 8'h00, 1'b1);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_TICK, 8'h00, 1'b0);
    queue_word(OP_MACK, 8'h00, 1'b1);
    queue_ticks(4);
    queue_word(OP_STOP, 8'h00, 1'b0);
    queue_ticks(4);
    gen_frames(200);
    wait_quiet();

    // back to back, no stalls on either side
    set_delays(8'd1, 8'd1);
    steady = 1'b1;
    @(negedge clk);
    gen_frames(300);
    wait_quiet();
    steady = 1'b0;

    set_delays(8'd2, 8'd3);
    @(negedge clk);
    gen_frames(200);
    wait_quiet();

    // longest steps, then shorten the delays while the stop is still running
    set_delays(8'd255, 8'd255);
    @(negedge clk);
    queue_word(OP_STOP, 8'h00, 1'b0);
    queue_ticks(300);
    wait_quiet();
    set_delays(8'd1, 8'd0);
    @(negedge clk);
    queue_ticks(260);
    wait_quiet();

    set_delays(8'd3, 8'd1);
    @(negedge clk);
    gen_frames(140);
    wait_quiet();

    repeat (20) @(posedge clk);
    $display("covered %0d tick words and %0d checked results over %0d delay settings,",
             words_in, results_seen, settings_run);
    $display("with %0d commands run to completion and %0d mismatches", cmds_done, err_count);
    if (err_count == 0 && line_q.size() == 0) begin
      $display("smbus_master_bit_engine_tb: done, clean");
    end else begin
      $display("smbus_master_bit_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
